FILE: hdl/damped_motion_rotation_matrix_assert.svh
// Assertion helpers for the damped motion rotation matrix block.
`ifndef DAMPED_MOTION_ROTATION_MATRIX_ASSERT_SVH
`define DAMPED_MOTION_ROTATION_MATRIX_ASSERT_SVH

// expr must never hold outside reset
`define DMRM_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("dmrm: forbidden condition");

// ante implies cons in the same cycle
`define DMRM_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dmrm: implication failed");

// ante implies cons in the following cycle
`define DMRM_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dmrm: next-cycle implication failed");

`endif

FILE: hdl/dmrm_pkg.sv
package dmrm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ANG_FRAC = 24;
	localparam int CORDIC_STEPS = 20;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_MOVE  = 2'd0;
	localparam func_t FUNC_TURN  = 2'd1;
	localparam func_t FUNC_FRAME = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MOVE_STEP  = 2'd0;
	localparam cfg_idx_t CFG_TURN_STEP  = 2'd1;
	localparam cfg_idx_t CFG_MOVE_DECAY = 2'd2;
	localparam cfg_idx_t CFG_TURN_DECAY = 2'd3;

	typedef logic signed [1:0] dir_t;
	localparam dir_t DIR_ZERO  = 2'sb00;
	localparam dir_t DIR_POS   = 2'sb01;
	localparam dir_t DIR_NEG2  = 2'sb10;
	localparam dir_t DIR_NEG   = 2'sb11;

	// 360 and 90 degrees in angle units
	localparam logic [32:0] PERIOD  = 33'(360) << FRAC_BITS;
	localparam logic [32:0] QUARTER = 33'(90) << FRAC_BITS;

	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

	function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:    v = 34'sd754974720;
			5'd1:    v = 34'sd445687602;
			5'd2:    v = 34'sd235489088;
			5'd3:    v = 34'sd119537938;
			5'd4:    v = 34'sd60000934;
			5'd5:    v = 34'sd30029717;
			5'd6:    v = 34'sd15018523;
			5'd7:    v = 34'sd7509720;
			5'd8:    v = 34'sd3754917;
			5'd9:    v = 34'sd1877466;
			5'd10:   v = 34'sd938734;
			5'd11:   v = 34'sd469367;
			5'd12:   v = 34'sd234684;
			5'd13:   v = 34'sd117342;
			5'd14:   v = 34'sd58671;
			5'd15:   v = 34'sd29335;
			5'd16:   v = 34'sd14668;
			5'd17:   v = 34'sd7334;
			5'd18:   v = 34'sd3667;
			5'd19:   v = 34'sd1833;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/dmrm_cmd_if.sv
interface dmrm_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [1:0] axis;
	logic signed [1:0] direction;

	modport source (output valid, func, axis, direction, input ready);
	modport sink (input valid, func, axis, direction, output ready);
endinterface

FILE: hdl/dmrm_rsp_if.sv
interface dmrm_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] row;
	logic signed [17:0] col0;
	logic signed [17:0] col1;
	logic signed [17:0] col2;
	logic signed [31:0] shift;
	logic last;

	modport source (output valid, row, col0, col1, col2, shift, last, input ready);
	modport sink (input valid, row, col0, col1, col2, shift, last, output ready);
endinterface

FILE: hdl/dmrm_cfg_if.sv
interface dmrm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/damped_motion_rotation_matrix.sv
// Damped motion and Euler-angle rotation matrix. Move and turn transactions
// on cmd update one offset or angle (none for axis 3) and produce no result.
// A frame tick runs a sequencer around one shared 32x18 multiplier, one
// compare/subtract reducer and one CORDIC add/shift stage: per axis a setup
// step, angle reduction, 20 CORDIC iterations, sine/cosine rounding and the
// matrix product (two multiply-accumulates per entry, two entries per row).
// Three rows then go out on rsp, each held until rsp is ready, and the six
// decays each take a multiply and a write-back. cmd is not ready until the
// frame is finished. cfg writes are always accepted.
`include "damped_motion_rotation_matrix_assert.svh"

module damped_motion_rotation_matrix (
	input  logic clk,
	input  logic arst_n,
	dmrm_cmd_if.sink   cmd,
	dmrm_rsp_if.source rsp,
	dmrm_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LDA, ST_RED, ST_ROT, ST_SC, ST_MUL, ST_ACC,
		ST_LOAD, ST_EMIT, ST_DMUL, ST_DWR
	} state_t;

	state_t state_q;

	logic signed [31:0] move_step_q, turn_step_q;
	logic [16:0] move_decay_q, turn_decay_q;

	// entries 0..2 offsets, 3..5 angles
	logic signed [31:0] st_q [6];
	logic signed [17:0] m_q [3][3];

	logic [1:0] ax_q, row_q;
	logic col_q, k_q;
	logic [3:0] red_q;
	logic [4:0] it_q;
	logic [2:0] d_q;
	logic [1:0] quad_q;
	logic [32:0] r_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [17:0] c_q, s_q, tp_q;
	logic signed [49:0] prod_q;
	logic signed [50:0] acc_q;

	logic [1:0] rsp_row_q;
	logic signed [17:0] rsp_c0_q, rsp_c1_q, rsp_c2_q;
	logic signed [31:0] rsp_shift_q;
	logic rsp_last_q, rsp_valid_q;

	function automatic logic signed [17:0] sat_q16(input logic signed [50:0] v);
		if (v > 51'sd65536)
			return dmrm_pkg::ONE_Q16;
		else if (v < -51'sd65536)
			return -dmrm_pkg::ONE_Q16;
		else
			return v[17:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);

	assign rsp.valid = rsp_valid_q;
	assign rsp.row   = rsp_row_q;
	assign rsp.col0  = rsp_c0_q;
	assign rsp.col1  = rsp_c1_q;
	assign rsp.col2  = rsp_c2_q;
	assign rsp.shift = rsp_shift_q;
	assign rsp.last  = rsp_last_q;

	// rotation plane of the current axis
	logic [1:0] ip, in_n;
	always_comb begin
		case (ax_q)
			2'd0:    begin ip = 2'd1; in_n = 2'd2; end
			2'd1:    begin ip = 2'd2; in_n = 2'd0; end
			default: begin ip = 2'd0; in_n = 2'd1; end
		endcase
	end

	// single read port on the offset/angle file
	logic [2:0] rd_idx;
	logic signed [31:0] rd_val;
	always_comb begin
		case (state_q)
			ST_IDLE: rd_idx = (cmd.func == dmrm_pkg::FUNC_TURN) ?
				3'({1'b0, cmd.axis} + 3'd3) : {1'b0, cmd.axis};
			ST_LDA:  rd_idx = 3'({1'b0, ax_q} + 3'd3);
			ST_LOAD: rd_idx = {1'b0, row_q};
			default: rd_idx = d_q;
		endcase
		rd_val = (rd_idx < 3'd6) ? st_q[rd_idx] : 32'sd0;
	end

	// move / turn update with saturation
	logic signed [31:0] step;
	logic signed [34:0] sd, diff;
	logic signed [31:0] upd;
	always_comb begin
		step = (cmd.func == dmrm_pkg::FUNC_TURN) ? turn_step_q : move_step_q;
		case (cmd.direction)
			dmrm_pkg::DIR_POS:  sd = 35'(step);
			dmrm_pkg::DIR_NEG:  sd = -35'(step);
			dmrm_pkg::DIR_NEG2: sd = -(35'(step) <<< 1);
			default:            sd = 35'sd0;
		endcase
		diff = 35'(rd_val) - sd;
		if (diff > 35'sd2147483647)
			upd = 32'sh7fffffff;
		else if (diff < -35'sd2147483648)
			upd = 32'sh80000000;
		else
			upd = diff[31:0];
	end

	// angle reduction: restoring subtract of 360<<k, then quadrant bits
	logic [32:0] red_k, r_next;
	logic red_ge;
	always_comb begin
		if (red_q < 4'd8)
			red_k = dmrm_pkg::PERIOD << (3'd7 - red_q[2:0]);
		else
			red_k = dmrm_pkg::QUARTER << (4'd9 - red_q);
		red_ge = (r_q >= red_k);
		r_next = red_ge ? (r_q - red_k) : r_q;
	end

	// CORDIC stage
	logic signed [33:0] dx, dy;
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;

	logic signed [33:0] xr, yr;
	logic signed [17:0] cc, ss;
	assign xr = (x_q + 34'sd8192) >>> 14;
	assign yr = (y_q + 34'sd8192) >>> 14;
	assign cc = sat_q16(51'(xr));
	assign ss = sat_q16(51'(yr));

	// shared multiplier operands
	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;
	logic [16:0] dsel, dlim;
	always_comb begin
		dsel = (d_q < 3'd3) ? move_decay_q : turn_decay_q;
		dlim = (dsel > 17'd65536) ? 17'd65536 : dsel;
		if (state_q == ST_DMUL) begin
			mul_a = rd_val;
			mul_b = 18'(17'd65536 - dlim);
		end else begin
			mul_a = 32'(m_q[row_q][k_q ? in_n : ip]);
			case ({col_q, k_q})
				2'b00:   mul_b = c_q;
				2'b01:   mul_b = s_q;
				2'b10:   mul_b = -s_q;
				default: mul_b = c_q;
			endcase
		end
	end

	logic signed [50:0] sum, sum_r;
	logic signed [17:0] t_ent;
	assign sum = acc_q + 51'(prod_q);
	assign sum_r = (sum + 51'sd32768) >>> 16;
	assign t_ent = sat_q16(sum_r);

	// decay, rounded toward zero
	logic signed [49:0] neg_p;
	logic signed [31:0] dec_val;
	always_comb begin
		neg_p = -prod_q;
		if (prod_q >= 0)
			dec_val = prod_q[47:16];
		else
			dec_val = -(neg_p[47:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			move_step_q <= '0;
			turn_step_q <= '0;
			move_decay_q <= '0;
			turn_decay_q <= '0;
			for (int i = 0; i < 6; i++)
				st_q[i] <= '0;
			ax_q <= '0;
			row_q <= '0;
			col_q <= 1'b0;
			k_q <= 1'b0;
			red_q <= '0;
			it_q <= '0;
			d_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					dmrm_pkg::CFG_MOVE_STEP:  move_step_q <= cfg.data;
					dmrm_pkg::CFG_TURN_STEP:  turn_step_q <= cfg.data;
					dmrm_pkg::CFG_MOVE_DECAY: move_decay_q <= cfg.data[16:0];
					dmrm_pkg::CFG_TURN_DECAY: turn_decay_q <= cfg.data[16:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						if ((cmd.func == dmrm_pkg::FUNC_MOVE ||
							cmd.func == dmrm_pkg::FUNC_TURN) && cmd.axis != 2'd3)
							st_q[rd_idx] <= upd;
						else if (cmd.func == dmrm_pkg::FUNC_FRAME) begin
							for (int i = 0; i < 3; i++)
								for (int j = 0; j < 3; j++)
									m_q[i][j] <= (i == j) ? dmrm_pkg::ONE_Q16 : 18'sd0;
							ax_q <= '0;
							state_q <= ST_LDA;
						end
					end
				end
				ST_LDA: begin
					// bias by 128 periods so the value is non-negative
					r_q <= 33'(rd_val) + (dmrm_pkg::PERIOD << 7);
					red_q <= '0;
					state_q <= ST_RED;
				end
				ST_RED: begin
					r_q <= r_next;
					if (red_q == 4'd8)
						quad_q[1] <= red_ge;
					if (red_q == 4'd9) begin
						quad_q[0] <= red_ge;
						z_q <= 34'(r_next) <<< (dmrm_pkg::ANG_FRAC - dmrm_pkg::FRAC_BITS);
						x_q <= dmrm_pkg::CORDIC_X0;
						y_q <= '0;
						it_q <= '0;
						state_q <= ST_ROT;
					end else
						red_q <= red_q + 4'd1;
				end
				ST_ROT: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - dmrm_pkg::atan_deg(it_q);
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + dmrm_pkg::atan_deg(it_q);
					end
					if (it_q == 5'(dmrm_pkg::CORDIC_STEPS - 1))
						state_q <= ST_SC;
					else
						it_q <= it_q + 5'd1;
				end
				ST_SC: begin
					case (quad_q)
						2'd0:    begin c_q <= cc;  s_q <= ss;  end
						2'd1:    begin c_q <= -ss; s_q <= cc;  end
						2'd2:    begin c_q <= -cc; s_q <= -ss; end
						default: begin c_q <= ss;  s_q <= -cc; end
					endcase
					row_q <= '0;
					col_q <= 1'b0;
					k_q <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= mul_a * mul_b;
					if (!k_q)
						acc_q <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!k_q) begin
						acc_q <= sum;
						k_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						k_q <= 1'b0;
						if (!col_q) begin
							tp_q <= t_ent;
							col_q <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							m_q[row_q][ip] <= tp_q;
							m_q[row_q][in_n] <= t_ent;
							col_q <= 1'b0;
							if (row_q == 2'd2) begin
								row_q <= '0;
								if (ax_q == 2'd2)
									state_q <= ST_LOAD;
								else begin
									ax_q <= ax_q + 2'd1;
									state_q <= ST_LDA;
								end
							end else begin
								row_q <= row_q + 2'd1;
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_LOAD: begin
					rsp_row_q <= row_q;
					rsp_c0_q <= m_q[row_q][0];
					rsp_c1_q <= m_q[row_q][1];
					rsp_c2_q <= m_q[row_q][2];
					rsp_shift_q <= rd_val;
					rsp_last_q <= (row_q == 2'd2);
					rsp_valid_q <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
						if (row_q == 2'd2) begin
							d_q <= '0;
							state_q <= ST_DMUL;
						end else begin
							row_q <= row_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DMUL: begin
					prod_q <= mul_a * mul_b;
					state_q <= ST_DWR;
				end
				ST_DWR: begin
					st_q[d_q] <= dec_val;
					if (d_q == 3'd5)
						state_q <= ST_IDLE;
					else begin
						d_q <= d_q + 3'd1;
						state_q <= ST_DMUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DMRM_NEVER(a_no_overlap, clk, arst_n, cmd.ready && rsp.valid)
	`DMRM_IMPL(a_last_row, clk, arst_n, rsp.valid, rsp.last == (rsp.row == 2'd2))
	`DMRM_NEXT(a_frame_busy, clk, arst_n,
		cmd.valid && cmd.ready && cmd.func == dmrm_pkg::FUNC_FRAME, !cmd.ready)

endmodule

FILE: bench/dmrm_checker.sv
`timescale 1ns / 100ps

module dmrm_checker (
	input  logic clk,
	input  logic arst_n,
	dmrm_cmd_if  cmd,
	dmrm_rsp_if  rsp,
	dmrm_cfg_if  cfg,
	output int   fails,
	output int   pending
);

	typedef struct {
		logic [1:0]         row;
		logic signed [17:0] col0;
		logic signed [17:0] col1;
		logic signed [17:0] col2;
		logic signed [31:0] shift;
		logic               last;
	} row_t;

	row_t rows_due[$];

	longint thrust, spin;
	logic [16:0] thrust_fade, spin_fade;
	int pos [3];
	int rot [3];

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip_one(input longint v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic int fade(input int v, input logic [16:0] d);
		longint keep, p;
		keep = 65536 - ((d > 17'd65536) ? 65536 : longint'(d));
		p = longint'(v) * keep;
		if (p >= 0) return int'(p >>> 16);
		return int'(-((-p) >>> 16));
	endfunction

	task automatic sin_cos(input int a, output longint c, output longint s);
		longint period, quarter, r, q, z, x, y, dx, dy, cc, ss;
		period = longint'(360) << dmrm_pkg::FRAC_BITS;
		quarter = longint'(90) << dmrm_pkg::FRAC_BITS;
		r = longint'(a) % period;
		if (r < 0) r += period;
		q = r / quarter;
		z = (r - q * quarter) << (dmrm_pkg::ANG_FRAC - dmrm_pkg::FRAC_BITS);
		x = 652032874;
		y = 0;
		for (int i = 0; i < dmrm_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(dmrm_pkg::atan_deg(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(dmrm_pkg::atan_deg(5'(i)));
			end
		end
		cc = clip_one((x + (longint'(1) << 13)) >>> 14);
		ss = clip_one((y + (longint'(1) << 13)) >>> 14);
		case (q)
			0: begin c = cc; s = ss; end
			1: begin c = -ss; s = cc; end
			2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endtask

	task automatic frame_rows();
		longint m [3][3];
		longint r [3][3];
		longint t [3][3];
		longint c, s, acc;
		int p, n;
		row_t e;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = (i == j) ? 65536 : 0;
		for (int ax = 0; ax < 3; ax++) begin
			p = (ax + 1) % 3;
			n = (ax + 2) % 3;
			sin_cos(rot[ax], c, s);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					r[i][j] = (i == j) ? 65536 : 0;
			r[p][p] = c; r[p][n] = -s;
			r[n][p] = s; r[n][n] = c;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += m[i][k] * r[k][j];
					t[i][j] = clip_one((acc + (longint'(1) << 15)) >>> 16);
				end
			m = t;
		end
		for (int k = 0; k < 3; k++) begin
			e.row = 2'(k);
			e.col0 = 18'(m[k][0]);
			e.col1 = 18'(m[k][1]);
			e.col2 = 18'(m[k][2]);
			e.shift = pos[k];
			e.last = (k == 2);
			rows_due.push_back(e);
		end
		for (int k = 0; k < 3; k++) begin
			pos[k] = fade(pos[k], thrust_fade);
			rot[k] = fade(rot[k], spin_fade);
		end
	endtask

	task automatic apply_cmd(input dmrm_pkg::func_t f, input logic [1:0] a,
		input dmrm_pkg::dir_t d);
		if ((f == dmrm_pkg::FUNC_MOVE || f == dmrm_pkg::FUNC_TURN) && a != 2'd3) begin
			if (f == dmrm_pkg::FUNC_MOVE)
				pos[a] = int'(sat32(longint'(pos[a]) - thrust * longint'(d)));
			else
				rot[a] = int'(sat32(longint'(rot[a]) - spin * longint'(d)));
		end else if (f == dmrm_pkg::FUNC_FRAME)
			frame_rows();
	endtask

	task automatic check_row();
		row_t e;
		if (rows_due.size() == 0) begin
			$error("row transaction with nothing expected: row %0d", rsp.row);
			fails++;
			return;
		end
		e = rows_due.pop_front();
		if (rsp.row !== e.row) begin
			$error("row: expected %0d, got %0d", e.row, rsp.row); fails++;
		end
		if (rsp.col0 !== e.col0) begin
			$error("col0: expected %0d, got %0d", e.col0, rsp.col0); fails++;
		end
		if (rsp.col1 !== e.col1) begin
			$error("col1: expected %0d, got %0d", e.col1, rsp.col1); fails++;
		end
		if (rsp.col2 !== e.col2) begin
			$error("col2: expected %0d, got %0d", e.col2, rsp.col2); fails++;
		end
		if (rsp.shift !== e.shift) begin
			$error("shift: expected %0d, got %0d", e.shift, rsp.shift); fails++;
		end
		if (rsp.last !== e.last) begin
			$error("last: expected %0d, got %0d", e.last, rsp.last); fails++;
		end
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust = 0; spin = 0; thrust_fade = 0; spin_fade = 0;
			for (int k = 0; k < 3; k++) begin
				pos[k] = 0; rot[k] = 0;
			end
			pending = rows_due.size();
		end else begin
			if (rsp.valid && rsp.ready)
				check_row();
			if (cfg.valid && cfg.ready)
				case (dmrm_pkg::cfg_idx_t'(cfg.index))
					dmrm_pkg::CFG_MOVE_STEP:  thrust = longint'(signed'(cfg.data));
					dmrm_pkg::CFG_TURN_STEP:  spin = longint'(signed'(cfg.data));
					dmrm_pkg::CFG_MOVE_DECAY: thrust_fade = cfg.data[16:0];
					dmrm_pkg::CFG_TURN_DECAY: spin_fade = cfg.data[16:0];
					default: ;
				endcase
			if (cmd.valid && cmd.ready)
				apply_cmd(cmd.func, cmd.axis, cmd.direction);
			pending = rows_due.size();
		end
	end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fails, pending, cycles = 0, burst_left = 0;
	int stall_mode = 0, stall_left = 0;

	dmrm_cmd_if cmd ();
	dmrm_rsp_if rsp ();
	dmrm_cfg_if cfg ();

	damped_motion_rotation_matrix dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.cfg(cfg));

	dmrm_checker chk (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp), .cfg(cfg),
		.fails(fails), .pending(pending));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("damped_motion_rotation_matrix test failed");
			$finish;
		end
	end

	// result side stall pattern: always ready, coin flip, or mostly stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(5, 40);
		end
		stall_left--;
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= 1'($urandom_range(0, 1));
			default: rsp.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic push_cmd(input dmrm_pkg::func_t f, input logic [1:0] a,
		input dmrm_pkg::dir_t d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.axis <= a;
		cmd.direction <= d;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic settle();
		cmd.valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input dmrm_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] ms, ts, md, td);
		write_reg(dmrm_pkg::CFG_MOVE_STEP, ms);
		write_reg(dmrm_pkg::CFG_TURN_STEP, ts);
		write_reg(dmrm_pkg::CFG_MOVE_DECAY, md);
		write_reg(dmrm_pkg::CFG_TURN_DECAY, td);
	endtask

	task automatic random_item();
		int pick;
		dmrm_pkg::dir_t d;
		pick = $urandom_range(0, 99);
		d = ($urandom_range(0, 1) != 0) ? dmrm_pkg::DIR_POS : dmrm_pkg::DIR_NEG;
		if ($urandom_range(0, 19) == 0) d = dmrm_pkg::dir_t'($urandom_range(0, 3));
		if (pick < 35)
			push_cmd(dmrm_pkg::FUNC_FRAME, 2'($urandom_range(0, 3)),
				dmrm_pkg::dir_t'($urandom_range(0, 3)));
		else if (pick < 65) push_cmd(dmrm_pkg::FUNC_MOVE, 2'($urandom_range(0, 2)), d);
		else if (pick < 95) push_cmd(dmrm_pkg::FUNC_TURN, 2'($urandom_range(0, 2)), d);
		else if (pick < 98) push_cmd(dmrm_pkg::func_t'($urandom_range(0, 1)), 2'd3, d);
		else push_cmd(2'd3, 2'($urandom_range(0, 3)), d);
	endtask

	initial begin
		cmd.valid = 1'b0; cmd.func = dmrm_pkg::FUNC_MOVE; cmd.axis = 2'd0;
		cmd.direction = dmrm_pkg::DIR_ZERO;
		cfg.valid = 1'b0; cfg.index = dmrm_pkg::CFG_MOVE_STEP; cfg.data = 32'd0;
		rsp.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: all functions, both signs, zero and -2 direction, unused codes
		push_cmd(dmrm_pkg::FUNC_FRAME, 2'd0, dmrm_pkg::DIR_ZERO);
		settle();
		set_regs(32'h0001_8000, 32'h001E_0000, 32'd8192, 32'd4096);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd0, dmrm_pkg::DIR_POS);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd1, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd2, dmrm_pkg::DIR_NEG2);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd0, dmrm_pkg::DIR_ZERO);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd3, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd0, dmrm_pkg::DIR_POS);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd1, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd2, dmrm_pkg::DIR_NEG2);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd3, dmrm_pkg::DIR_POS);
		push_cmd(2'd3, 2'd3, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_FRAME, 2'd3, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_FRAME, 2'd1, dmrm_pkg::DIR_POS);
		settle();

		// saturation with extreme steps, decay of one and above one
		set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd131071);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd0, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd0, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd1, dmrm_pkg::DIR_POS);
		push_cmd(dmrm_pkg::FUNC_MOVE, 2'd1, dmrm_pkg::DIR_NEG2);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd2, dmrm_pkg::DIR_POS);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd0, dmrm_pkg::DIR_NEG2);
		push_cmd(dmrm_pkg::FUNC_TURN, 2'd1, dmrm_pkg::DIR_NEG);
		push_cmd(dmrm_pkg::FUNC_FRAME, 2'd0, dmrm_pkg::DIR_POS);
		push_cmd(dmrm_pkg::FUNC_FRAME, 2'd2, dmrm_pkg::DIR_NEG2);
		settle();

		// random phases across several register settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_regs($urandom, $urandom_range(0, 32'h00B4_0000), 32'd0, 32'd0);
				1: set_regs(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 65536),
					$urandom_range(0, 65536));
				2: set_regs($urandom_range(0, 32'h0010_0000), -$urandom_range(0, 32'h005A_0000),
					$urandom_range(0, 2000), $urandom_range(0, 2000));
				default: set_regs($urandom, $urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < 20; n++) begin
				if (ph == 1 && n == 12) begin
					// hold off until all rows have drained
					cmd.valid <= 1'b0;
					burst_left = 0;
					wait (pending == 0);
					@(negedge clk);
				end
				random_item();
			end
			settle();
		end

		repeat (200) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("damped_motion_rotation_matrix test passed");
		else
			$display("damped_motion_rotation_matrix test failed");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/dmrm_pkg.sv
hdl/dmrm_cmd_if.sv
hdl/dmrm_rsp_if.sv
hdl/dmrm_cfg_if.sv
hdl/damped_motion_rotation_matrix.sv
bench/dmrm_checker.sv
bench/tb_top.sv
